@@ rtl/core/ffha_pkg.sv @@
`default_nettype none
package ffha_pkg;

	localparam int HEAP_BYTES   = 1048576;
	localparam int BLOCK_BYTES  = 64;
	localparam int HEADER_BYTES = 16;
	localparam int MAX_BLOCKS   = 64;

	localparam int ADDR_W  = 20;
	localparam int START_W = $clog2(HEAP_BYTES);
	localparam int SIZE_W  = $clog2(HEAP_BYTES + 1);
	localparam int NEED_W  = SIZE_W + 1;
	localparam int IDX_W   = $clog2(MAX_BLOCKS);
	localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);
	localparam int CMP_W   = (START_W > ADDR_W) ? START_W : ADDR_W;
	localparam int SUM_W   = CMP_W + 2;

	typedef struct packed {
		logic [START_W-1:0] start;
		logic [SIZE_W-1:0]  size;
	} span_t;

	localparam span_t INIT_SPAN = '{start: '0, size: SIZE_W'(HEAP_BYTES)};

	// table-wide operations; DELSET loads the entry just below pos and closes the gap at pos
	typedef enum logic [2:0] {
		T_HOLD, T_ROT, T_DEL, T_INS, T_SET, T_DELSET
	} tbl_op_t;

	typedef enum logic [1:0] {
		C_HOLD, C_NXT, C_PRV, C_LOAD
	} cell_sel_t;

	typedef struct packed {
		tbl_op_t          op;
		logic [IDX_W-1:0] pos;
		span_t            data;
	} tbl_cmd_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NOFIT   = 2'd1,
		ST_BADADDR = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

endpackage
`default_nettype wire

@@ rtl/core/ffha_cell.sv @@
`default_nettype none
module ffha_cell
	import ffha_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire cell_sel_t sel,
	input  wire span_t     nxt,
	input  wire span_t     prv,
	input  wire span_t     bcast,
	output span_t          q
);

	span_t span_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_q <= INIT_SPAN;
		end else begin
			case (sel)
				C_NXT:   span_q <= nxt;
				C_PRV:   span_q <= prv;
				C_LOAD:  span_q <= bcast;
				default: span_q <= span_q;
			endcase
		end
	end

	assign q = span_q;

endmodule
`default_nettype wire

@@ rtl/core/ffha_table.sv @@
`default_nettype none
module ffha_table
	import ffha_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire tbl_cmd_t cmd,
	output span_t         head
);

	span_t     cq  [MAX_BLOCKS];
	cell_sel_t sel [MAX_BLOCKS];

	for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
		always_comb begin
			sel[i] = C_HOLD;
			case (cmd.op)
				T_ROT: sel[i] = C_NXT;
				T_DEL: begin
					if (i >= int'(cmd.pos)) sel[i] = C_NXT;
				end
				T_INS: begin
					if (i > int'(cmd.pos)) sel[i] = C_PRV;
					else if (i == int'(cmd.pos)) sel[i] = C_LOAD;
				end
				T_SET: begin
					if (i == int'(cmd.pos)) sel[i] = C_LOAD;
				end
				T_DELSET: begin
					if (i >= int'(cmd.pos)) sel[i] = C_NXT;
					else if (i + 1 == int'(cmd.pos)) sel[i] = C_LOAD;
				end
				default: sel[i] = C_HOLD;
			endcase
		end

		ffha_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.sel   (sel[i]),
			.nxt   (cq[(i + 1) % MAX_BLOCKS]),
			.prv   (cq[(i + MAX_BLOCKS - 1) % MAX_BLOCKS]),
			.bcast (cmd.data),
			.q     (cq[i])
		);
	end

	assign head = cq[0];

endmodule
`default_nettype wire

@@ rtl/core/first_fit_heap_allocator.sv @@
// channel   signals                               direction  handshake
// request   opcode, request_size, address         in         start && !busy
// result    status, address_out                   out        done, one cycle
//
// Every transaction runs in order from accept to the done strobe: the free-range chain
// is rotated fully past its head cell, then the taken-block chain is rotated fully,
// then S_APPLY applies the shift/insert/update, and the registered result follows.
// Reset (arst_n low) restores one free range covering the heap, no taken blocks.
// busy is high from accept until the cycle done is shown; results cannot stall.
`default_nettype none
module first_fit_heap_allocator
	import ffha_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic              opcode,
	input  wire logic [ADDR_W-1:0] request_size,
	input  wire logic [ADDR_W-1:0] address,
	output logic                   done,
	output logic [1:0]             status,
	output logic [ADDR_W-1:0]      address_out
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SCANF = 4'b0010,
		S_SCANT = 4'b0100,
		S_APPLY = 4'b1000
	} state_t;

	state_t             state_q;
	logic [IDX_W-1:0]   k_q;
	logic [CNT_W-1:0]   free_cnt_q, taken_cnt_q;
	logic               op_q, bad_q;
	logic [NEED_W-1:0]  need_q;
	logic [CMP_W-1:0]   base_q;
	logic               ffound_q, tfound_q, lo_v_q;
	logic [IDX_W-1:0]   fpos_q, tpos_q;
	span_t              fspan_q, lo_q;
	logic [SIZE_W-1:0]  bsz_q;
	logic               done_q;
	status_t            status_q;
	logic [ADDR_W-1:0]  addr_q;

	tbl_cmd_t fcmd, tcmd;
	span_t    fhead, thead;

	ffha_table u_free  (.clk(clk), .arst_n(arst_n), .cmd(fcmd), .head(fhead));
	ffha_table u_taken (.clk(clk), .arst_n(arst_n), .cmd(tcmd), .head(thead));

	logic              accept, last_k, fvalid, tvalid;
	logic [NEED_W-1:0] need_d;
	logic [CMP_W-1:0]  fh_start, th_start;
	logic [CNT_W-1:0]  fpos_eff, tpos_eff;
	logic              alloc_fit, alloc_ok, exact, jlo, jhi, free_ok;
	span_t             carved;

	assign accept   = start && !busy;
	assign busy     = (state_q != S_IDLE);
	assign last_k   = (k_q == IDX_W'(MAX_BLOCKS - 1));
	assign fvalid   = (CNT_W'(k_q) < free_cnt_q);
	assign tvalid   = (CNT_W'(k_q) < taken_cnt_q);
	assign fh_start = CMP_W'(fhead.start);
	assign th_start = CMP_W'(thead.start);

	always_comb begin
		if (request_size > ADDR_W'(BLOCK_BYTES))
			need_d = NEED_W'((NEED_W'(request_size / BLOCK_BYTES) + NEED_W'(1)) *
				NEED_W'(BLOCK_BYTES) + NEED_W'(HEADER_BYTES));
		else
			need_d = NEED_W'(BLOCK_BYTES + HEADER_BYTES);
	end

	assign fpos_eff  = ffound_q ? CNT_W'(fpos_q) : free_cnt_q;
	assign tpos_eff  = tfound_q ? CNT_W'(tpos_q) : taken_cnt_q;
	assign alloc_fit = ffound_q;
	assign alloc_ok  = !op_q && ffound_q && (taken_cnt_q != CNT_W'(MAX_BLOCKS));
	assign exact     = (NEED_W'(fspan_q.size) == need_q);
	assign carved    = '{start: START_W'(NEED_W'(fspan_q.start) + need_q),
		size: SIZE_W'(NEED_W'(fspan_q.size) - need_q)};
	assign jlo = lo_v_q &&
		(SUM_W'(lo_q.start) + SUM_W'(lo_q.size) == SUM_W'(base_q));
	assign jhi = ffound_q &&
		(SUM_W'(base_q) + SUM_W'(bsz_q) == SUM_W'(fspan_q.start));
	assign free_ok = op_q && !bad_q && tfound_q &&
		(jlo || jhi || (free_cnt_q != CNT_W'(MAX_BLOCKS)));

	always_comb begin
		fcmd = '{op: T_HOLD, pos: '0, data: fspan_q};
		tcmd = '{op: T_HOLD, pos: '0, data: fspan_q};
		case (state_q)
			S_SCANF: fcmd.op = T_ROT;
			S_SCANT: tcmd.op = T_ROT;
			S_APPLY: begin
				if (alloc_ok) begin
					fcmd.pos  = fpos_q;
					fcmd.op   = exact ? T_DEL : T_SET;
					fcmd.data = carved;
					tcmd.op   = T_INS;
					tcmd.pos  = IDX_W'(tpos_eff);
					tcmd.data = '{start: fspan_q.start, size: SIZE_W'(need_q)};
				end else if (free_ok) begin
					tcmd.op  = T_DEL;
					tcmd.pos = tpos_q;
					if (jlo && jhi) begin
						fcmd.op   = T_DELSET;
						fcmd.pos  = IDX_W'(fpos_eff);
						fcmd.data = '{start: lo_q.start,
							size: SIZE_W'(lo_q.size + bsz_q + fspan_q.size)};
					end else if (jlo) begin
						fcmd.op   = T_SET;
						fcmd.pos  = IDX_W'(fpos_eff - CNT_W'(1));
						fcmd.data = '{start: lo_q.start, size: SIZE_W'(lo_q.size + bsz_q)};
					end else if (jhi) begin
						fcmd.op   = T_SET;
						fcmd.pos  = IDX_W'(fpos_eff);
						fcmd.data = '{start: START_W'(base_q),
							size: SIZE_W'(fspan_q.size + bsz_q)};
					end else begin
						fcmd.op   = T_INS;
						fcmd.pos  = IDX_W'(fpos_eff);
						fcmd.data = '{start: START_W'(base_q), size: bsz_q};
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			k_q         <= '0;
			free_cnt_q  <= CNT_W'(1);
			taken_cnt_q <= '0;
			done_q      <= 1'b0;
			ffound_q    <= 1'b0;
			tfound_q    <= 1'b0;
			lo_v_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q     <= opcode;
						need_q   <= need_d;
						bad_q    <= (address < ADDR_W'(HEADER_BYTES));
						base_q   <= CMP_W'(address - ADDR_W'(HEADER_BYTES));
						ffound_q <= 1'b0;
						tfound_q <= 1'b0;
						lo_v_q   <= 1'b0;
						k_q      <= '0;
						state_q  <= S_SCANF;
					end
				end
				S_SCANF: begin
					// head cell holds entry k_q while the chain rotates
					if (fvalid && !ffound_q) begin
						if (!op_q ? (NEED_W'(fhead.size) >= need_q) : (fh_start >= base_q)) begin
							ffound_q <= 1'b1;
							fpos_q   <= k_q;
							fspan_q  <= fhead;
						end else begin
							lo_v_q <= 1'b1;
							lo_q   <= fhead;
						end
					end
					k_q <= k_q + IDX_W'(1);
					if (last_k) state_q <= S_SCANT;
				end
				S_SCANT: begin
					if (tvalid && !tfound_q) begin
						if (!op_q ? (th_start >= CMP_W'(fspan_q.start)) : (th_start == base_q)) begin
							tfound_q <= 1'b1;
							tpos_q   <= k_q;
							bsz_q    <= thead.size;
						end
					end
					k_q <= k_q + IDX_W'(1);
					if (last_k) state_q <= S_APPLY;
				end
				S_APPLY: begin
					done_q  <= 1'b1;
					addr_q  <= '0;
					state_q <= S_IDLE;
					if (!op_q) begin
						if (!alloc_fit) begin
							status_q <= ST_NOFIT;
						end else if (!alloc_ok) begin
							status_q <= ST_FULL;
						end else begin
							status_q    <= ST_OK;
							addr_q      <= ADDR_W'(fspan_q.start + START_W'(HEADER_BYTES));
							taken_cnt_q <= taken_cnt_q + CNT_W'(1);
							if (exact) free_cnt_q <= free_cnt_q - CNT_W'(1);
						end
					end else begin
						if (bad_q || !tfound_q) begin
							status_q <= ST_BADADDR;
						end else if (!free_ok) begin
							status_q <= ST_FULL;
						end else begin
							status_q    <= ST_OK;
							taken_cnt_q <= taken_cnt_q - CNT_W'(1);
							if (jlo && jhi) free_cnt_q <= free_cnt_q - CNT_W'(1);
							else if (!jlo && !jhi) free_cnt_q <= free_cnt_q + CNT_W'(1);
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign address_out = addr_q;

`ifndef SYNTHESIS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("done while busy");
	a_free_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		free_cnt_q <= CNT_W'(MAX_BLOCKS)) else $error("free count overflow");
	a_taken_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		taken_cnt_q <= CNT_W'(MAX_BLOCKS)) else $error("taken count overflow");
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_OK) |-> (address_out == '0)) else $error("address on failure");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy) else $error("accepted transaction not busy");
`endif

endmodule
`default_nettype wire
